>>> rtl/ndlc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Nested delay-loop counter solver: shared package
// Types, tier codes and constants used by the front, queue and back sections.
// ----------------------------------------------------------------------------
package ndlc_pkg;

   localparam int DIV_STEPS = 9;
   localparam int FR_STAGES = DIV_STEPS + 1;
   localparam int BK_STAGES = 2 * DIV_STEPS + 2;
   localparam int Q_DEPTH   = 4;

   localparam logic [31:0] ONE_LOOP_LIMIT  = 32'd771;
   localparam logic [31:0] TWO_LOOP_LIMIT  = 32'd197125;
   localparam logic [18:0] TWO_LOOP_BIAS   = 19'd763;
   localparam logic [18:0] THREE_LOOP_BIAS = 19'd758;
   localparam logic [18:0] MIDDLE_STEP     = 19'd770;
   localparam logic [18:0] INNER_STEP      = 19'd3;
   localparam logic [8:0]  UNUSED_COUNT    = 9'h1FF;

   localparam logic [9:0]  MIN_RESET = 10'd3;
   localparam logic [25:0] MAX_RESET = 26'd50463000;

   localparam logic [1:0] REG_MIN_CYCLES = 2'd0;
   localparam logic [1:0] REG_MAX_CYCLES = 2'd1;

   typedef enum logic [2:0] {
      TIER_NONE,
      TIER_ONE,
      TIER_TWO,
      TIER_THREE,
      TIER_OVF
   } tier_type;

   typedef struct packed {
      logic [31:0] m;
      tier_type    tier;
      logic [26:0] rem;
      logic [8:0]  q;
   } fr_type;

   typedef struct packed {
      logic [31:0] m;
      tier_type    tier;
      logic [8:0]  c;
      logic [26:0] num;
      logic [18:0] denb;
      logic [9:0]  dena;
   } mid_type;

   typedef struct packed {
      logic [31:0] m;
      tier_type    tier;
      logic [8:0]  c;
      logic [26:0] rem;
      logic [18:0] denb;
      logic [9:0]  dena;
      logic [8:0]  qb;
      logic [8:0]  qa;
      logic [18:0] t;
   } bk_type;

   typedef struct packed {
      logic [8:0]  inner;
      logic [8:0]  middle;
      logic [8:0]  outer;
      logic [31:0] achieved;
      logic        ovf;
   } rsp_type;

endpackage
`default_nettype wire

>>> rtl/ndlc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Front section
// Accepts requests, sorts them into tiers, finds the outer count by a
// pipelined restoring division and prepares the operands of the back section.
// ----------------------------------------------------------------------------
module ndlc_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   output logic                 full,
   input  wire logic [31:0]     req_desired_cycles,
   input  wire logic [9:0]      min_cycles,
   input  wire logic [25:0]     max_cycles,
   output logic                 out_valid,
   output ndlc_pkg::mid_type    out_item,
   input  wire logic            out_ready
);

   logic [ndlc_pkg::FR_STAGES-1:0] valid_ff, valid_in;
   ndlc_pkg::fr_type               st_ff [ndlc_pkg::FR_STAGES];
   ndlc_pkg::fr_type               st_in [ndlc_pkg::FR_STAGES];
   logic                           tail_valid_ff;
   ndlc_pkg::mid_type              tail_ff, tail_in;
   logic                           adv;

   assign adv  = !tail_valid_ff || out_ready;
   assign full = !adv;

   always_comb begin
      logic [27:0] sden;
      logic [31:0] m;
      ndlc_pkg::fr_type p;
      logic [8:0]  c;
      logic [18:0] c758;
      m = req_desired_cycles;
      valid_in[0]     = push && adv;
      st_in[0].m      = m;
      st_in[0].rem    = 27'(m[26:0] - 27'd3);
      st_in[0].q      = '0;
      if (m < {22'd0, min_cycles}) begin
         st_in[0].tier = ndlc_pkg::TIER_NONE;
      end else if (m <= ndlc_pkg::ONE_LOOP_LIMIT) begin
         st_in[0].tier = ndlc_pkg::TIER_ONE;
      end else if (m <= ndlc_pkg::TWO_LOOP_LIMIT) begin
         st_in[0].tier = ndlc_pkg::TIER_TWO;
      end else if (m <= {6'd0, max_cycles}) begin
         st_in[0].tier = ndlc_pkg::TIER_THREE;
      end else begin
         st_in[0].tier = ndlc_pkg::TIER_OVF;
      end
      for (int i = 1; i < ndlc_pkg::FR_STAGES; i++) begin
         p    = st_ff[i-1];
         sden = 28'(ndlc_pkg::TWO_LOOP_LIMIT[17:0]) << (ndlc_pkg::DIV_STEPS - i);
         if ({1'b0, p.rem} >= sden) begin
            p.rem = 27'({1'b0, p.rem} - sden);
            p.q[ndlc_pkg::DIV_STEPS - i] = 1'b1;
         end
         st_in[i]    = p;
         valid_in[i] = valid_ff[i-1];
      end
      p = st_ff[ndlc_pkg::FR_STAGES-1];
      c = (p.tier == ndlc_pkg::TIER_THREE) ? 9'(p.q + 9'd1) : 9'd1;
      c758 = 19'({10'd0, c} * ndlc_pkg::THREE_LOOP_BIAS);
      tail_in.m    = p.m;
      tail_in.tier = p.tier;
      tail_in.c    = c;
      tail_in.denb = 19'({10'd0, c} * ndlc_pkg::MIDDLE_STEP);
      tail_in.dena = 10'({10'd0, c} * ndlc_pkg::INNER_STEP);
      case (p.tier)
         ndlc_pkg::TIER_THREE: tail_in.num = 27'(p.m[26:0] - 27'd3 + {8'd0, c758});
         ndlc_pkg::TIER_TWO:   tail_in.num = 27'(p.m[26:0] + {8'd0, ndlc_pkg::TWO_LOOP_BIAS});
         ndlc_pkg::TIER_ONE:   tail_in.num = p.m[26:0];
         default:              tail_in.num = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         tail_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff      <= valid_in;
         tail_valid_ff <= valid_ff[ndlc_pkg::FR_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff   <= st_in;
         tail_ff <= tail_in;
      end
   end

   assign out_valid = tail_valid_ff;
   assign out_item  = tail_ff;

endmodule
`default_nettype wire

>>> rtl/ndlc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Decoupling queue
// A short first-in first-out queue between the front and back sections.
// ----------------------------------------------------------------------------
module ndlc_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire ndlc_pkg::mid_type in_item,
   output logic                   in_ready,
   output logic                   out_valid,
   output ndlc_pkg::mid_type      out_item,
   input  wire logic              out_pop
);

   ndlc_pkg::mid_type mem_ff [ndlc_pkg::Q_DEPTH];
   logic [$clog2(ndlc_pkg::Q_DEPTH)-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [$clog2(ndlc_pkg::Q_DEPTH):0]   cnt_ff, cnt_in;
   logic wr_en, rd_en;

   assign in_ready  = cnt_ff != ($clog2(ndlc_pkg::Q_DEPTH)+1)'(ndlc_pkg::Q_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_item  = mem_ff[rd_ff];
   assign wr_en     = in_valid && in_ready;
   assign rd_en     = out_pop && out_valid;

   always_comb begin
      wr_in  = wr_en ? wr_ff + 1'b1 : wr_ff;
      rd_in  = rd_en ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (wr_en && !rd_en) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ff] <= in_item;
      end
   end

endmodule
`default_nettype wire

>>> rtl/ndlc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Back section
// Pipelined divisions for the middle and inner counts, the achieved cycle
// count and the result register.
// ----------------------------------------------------------------------------
module ndlc_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire ndlc_pkg::mid_type in_item,
   output logic                   in_pop,
   output logic                   empty,
   output ndlc_pkg::rsp_type      rsp,
   input  wire logic              pop
);

   logic [ndlc_pkg::BK_STAGES-1:0] valid_ff, valid_in;
   ndlc_pkg::bk_type               st_ff [ndlc_pkg::BK_STAGES];
   ndlc_pkg::bk_type               st_in [ndlc_pkg::BK_STAGES];
   logic                           out_valid_ff;
   ndlc_pkg::rsp_type              out_ff, out_in;
   logic                           adv;

   assign adv    = !out_valid_ff || pop;
   assign in_pop = adv && in_valid;

   always_comb begin
      logic [27:0] sden;
      logic [18:0] av;
      ndlc_pkg::bk_type p;
      int k;
      valid_in[0]    = in_valid;
      st_in[0].m     = in_item.m;
      st_in[0].tier  = in_item.tier;
      st_in[0].c     = in_item.c;
      st_in[0].rem   = in_item.num;
      st_in[0].denb  = in_item.denb;
      st_in[0].dena  = in_item.dena;
      st_in[0].qb    = '0;
      st_in[0].qa    = '0;
      st_in[0].t     = '0;
      for (int i = 1; i <= ndlc_pkg::DIV_STEPS; i++) begin
         p    = st_ff[i-1];
         k    = ndlc_pkg::DIV_STEPS - i;
         sden = {9'd0, p.denb} << k;
         if ({1'b0, p.rem} >= sden) begin
            p.rem   = 27'({1'b0, p.rem} - sden);
            p.qb[k] = 1'b1;
         end
         st_in[i]    = p;
         valid_in[i] = valid_ff[i-1];
      end
      for (int i = ndlc_pkg::DIV_STEPS + 1; i <= 2 * ndlc_pkg::DIV_STEPS; i++) begin
         p = st_ff[i-1];
         if (i == ndlc_pkg::DIV_STEPS + 1 && p.tier == ndlc_pkg::TIER_ONE) begin
            p.rem = p.m[26:0];
         end
         k    = 2 * ndlc_pkg::DIV_STEPS - i;
         sden = {18'd0, p.dena} << k;
         if ({1'b0, p.rem} >= sden) begin
            p.rem   = 27'({1'b0, p.rem} - sden);
            p.qa[k] = 1'b1;
         end
         st_in[i]    = p;
         valid_in[i] = valid_ff[i-1];
      end
      p = st_ff[ndlc_pkg::BK_STAGES-2];
      av = 19'({10'd0, p.qa} * ndlc_pkg::INNER_STEP);
      p.t = 19'(av + 19'({10'd0, p.qb} * ndlc_pkg::MIDDLE_STEP)
             - ((p.tier == ndlc_pkg::TIER_THREE) ? ndlc_pkg::THREE_LOOP_BIAS
                                                  : ndlc_pkg::TWO_LOOP_BIAS));
      st_in[ndlc_pkg::BK_STAGES-1]    = p;
      valid_in[ndlc_pkg::BK_STAGES-1] = valid_ff[ndlc_pkg::BK_STAGES-2];
   end

   always_comb begin
      ndlc_pkg::bk_type p;
      logic [8:0] a1;
      p = st_ff[ndlc_pkg::BK_STAGES-1];
      a1 = (p.qa == '0) ? 9'd0 : 9'(p.qa - 9'd1);
      out_in.inner    = ndlc_pkg::UNUSED_COUNT;
      out_in.middle   = ndlc_pkg::UNUSED_COUNT;
      out_in.outer    = ndlc_pkg::UNUSED_COUNT;
      out_in.achieved = p.m;
      out_in.ovf      = 1'b0;
      case (p.tier)
         ndlc_pkg::TIER_ONE: begin
            out_in.inner    = {1'b0, a1[7:0]};
            out_in.achieved = 32'({23'd0, (p.qa == '0) ? 9'd1 : p.qa} * 32'd3);
         end
         ndlc_pkg::TIER_TWO: begin
            out_in.inner    = {1'b0, p.qa[7:0]};
            out_in.middle   = {1'b0, p.qb[7:0]};
            out_in.achieved = {13'd0, p.t};
         end
         ndlc_pkg::TIER_THREE: begin
            out_in.inner    = {1'b0, p.qa[7:0]};
            out_in.middle   = {1'b0, p.qb[7:0]};
            out_in.outer    = {1'b0, p.c[7:0]};
            out_in.achieved = 32'({13'd0, p.t} * {23'd0, p.c}) + 32'd3;
         end
         ndlc_pkg::TIER_OVF: begin
            out_in.ovf = 1'b1;
         end
         default: begin
            out_in.ovf = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff     <= valid_in;
         out_valid_ff <= valid_ff[ndlc_pkg::BK_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff  <= st_in;
         out_ff <= out_in;
      end
   end

   assign empty = !out_valid_ff;
   assign rsp   = out_ff;

endmodule
`default_nettype wire

>>> rtl/nested_delay_loop_counter_solver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Nested delay-loop counter solver
// Splits a machine-cycle count into reload values for up to three nested
// 8-bit countdown loops and reports the cycle count they really take.
// ----------------------------------------------------------------------------
// A new request can be pushed every cycle while full is low; each request
// passes through three pipelined restoring dividers (outer count in the
// front section, middle and inner counts in the back section) plus the
// classify, operand and result stages. A four-entry queue between the
// sections and the result register let either side stall alone.
// Unused counts read all ones; configuration writes are always ready.
module nested_delay_loop_counter_solver (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [31:0] req_desired_cycles,
   output logic             empty,
   input  wire logic        pop,
   output logic [8:0]       rsp_inner_count,
   output logic [8:0]       rsp_middle_count,
   output logic [8:0]       rsp_outer_count,
   output logic [31:0]      rsp_achieved_cycles,
   output logic             rsp_overflow,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [25:0] csr_wdata
);

   logic [9:0]        min_ff;
   logic [25:0]       max_ff;
   logic              fr_valid, q_ready, q_valid, q_pop;
   ndlc_pkg::mid_type fr_item, q_item;
   ndlc_pkg::rsp_type rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= ndlc_pkg::MIN_RESET;
         max_ff <= ndlc_pkg::MAX_RESET;
      end else if (csr_valid) begin
         if (csr_index == ndlc_pkg::REG_MIN_CYCLES) begin
            min_ff <= csr_wdata[9:0];
         end else if (csr_index == ndlc_pkg::REG_MAX_CYCLES) begin
            max_ff <= csr_wdata;
         end
      end
   end

   ndlc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_desired_cycles (req_desired_cycles),
      .min_cycles         (min_ff),
      .max_cycles         (max_ff),
      .out_valid          (fr_valid),
      .out_item           (fr_item),
      .out_ready          (q_ready)
   );

   ndlc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_item   (fr_item),
      .in_ready  (q_ready),
      .out_valid (q_valid),
      .out_item  (q_item),
      .out_pop   (q_pop)
   );

   ndlc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (q_valid),
      .in_item  (q_item),
      .in_pop   (q_pop),
      .empty    (empty),
      .rsp      (rsp),
      .pop      (pop)
   );

   assign rsp_inner_count     = rsp.inner;
   assign rsp_middle_count    = rsp.middle;
   assign rsp_outer_count     = rsp.outer;
   assign rsp_achieved_cycles = rsp.achieved;
   assign rsp_overflow        = rsp.ovf;

endmodule
`default_nettype wire

>>> rtl/ndlc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Port checker
// Checks the result channel of the solver over time.
// ----------------------------------------------------------------------------
module ndlc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        empty,
   input wire logic        pop,
   input wire logic [8:0]  rsp_inner_count,
   input wire logic [8:0]  rsp_middle_count,
   input wire logic [8:0]  rsp_outer_count,
   input wire logic [31:0] rsp_achieved_cycles,
   input wire logic        rsp_overflow
);

   a_ovf_unused: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_overflow |-> rsp_inner_count == ndlc_pkg::UNUSED_COUNT &&
      rsp_middle_count == ndlc_pkg::UNUSED_COUNT && rsp_outer_count == ndlc_pkg::UNUSED_COUNT)
      else $error("overflow item carries a used count");

   a_outer_nested: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_outer_count != ndlc_pkg::UNUSED_COUNT |->
      rsp_middle_count != ndlc_pkg::UNUSED_COUNT && rsp_inner_count != ndlc_pkg::UNUSED_COUNT)
      else $error("outer loop used without inner loops");

   a_middle_nested: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_middle_count != ndlc_pkg::UNUSED_COUNT |->
      rsp_inner_count != ndlc_pkg::UNUSED_COUNT)
      else $error("middle loop used without inner loop");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_achieved_cycles))
      else $error("waiting item changed");

endmodule

bind nested_delay_loop_counter_solver ndlc_checker u_ndlc_checker (.*);
`default_nettype wire

>>> tb/delay_solution_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Delay solution checker
// Watches the request, result and register channels of the nested delay-loop
// counter solver, works out the loop counts each accepted item should give
// and compares every result item, field by field, with the oldest forecast.
// ----------------------------------------------------------------------------
module delay_solution_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire logic        full,
   input  wire logic [31:0] req_desired_cycles,
   input  wire logic        empty,
   input  wire logic        pop,
   input  wire logic [8:0]  rsp_inner_count,
   input  wire logic [8:0]  rsp_middle_count,
   input  wire logic [8:0]  rsp_outer_count,
   input  wire logic [31:0] rsp_achieved_cycles,
   input  wire logic        rsp_overflow,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [25:0] csr_wdata,
   output int               fail_count,
   output int               pending
);

   logic [9:0]        floor_cycles;
   logic [25:0]       ceiling_cycles;
   ndlc_pkg::rsp_type forecast_q[$];

   function automatic ndlc_pkg::rsp_type solve_loops(input logic [31:0] m,
                                                     input logic [9:0] lo,
                                                     input logic [25:0] hi);
      ndlc_pkg::rsp_type r;
      logic [63:0]       mm, s, av, bv, cv, n, rem;
      mm = {32'd0, m};
      r.inner    = ndlc_pkg::UNUSED_COUNT;
      r.middle   = ndlc_pkg::UNUSED_COUNT;
      r.outer    = ndlc_pkg::UNUSED_COUNT;
      r.achieved = m;
      r.ovf      = 1'b0;
      if (mm < {54'd0, lo}) begin
      end else if (mm <= 64'd771) begin
         av = (mm < 64'd3) ? 64'd0 : mm / 64'd3 - 64'd1;
         r.achieved = 32'(64'd3 * (av + 64'd1));
         r.inner    = {1'b0, av[7:0]};
      end else if (mm <= 64'd197125) begin
         s  = mm + 64'd763;
         bv = s / 64'd770;
         av = (s - 64'd770 * bv) / 64'd3;
         r.achieved = 32'(64'd3 * av + 64'd770 * bv - 64'd763);
         r.inner    = {1'b0, av[7:0]};
         r.middle   = {1'b0, bv[7:0]};
      end else if (mm <= {38'd0, hi}) begin
         cv  = (mm - 64'd3) / 64'd197125 + 64'd1;
         n   = mm - 64'd3 + 64'd758 * cv;
         bv  = n / (64'd770 * cv);
         rem = n - 64'd770 * bv * cv;
         av  = rem / (64'd3 * cv);
         r.achieved = 32'((64'd3 * av + 64'd770 * bv - 64'd758) * cv + 64'd3);
         r.inner    = {1'b0, av[7:0]};
         r.middle   = {1'b0, bv[7:0]};
         r.outer    = {1'b0, cv[7:0]};
      end else begin
         r.ovf = 1'b1;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      ndlc_pkg::rsp_type want;
      if (reset) begin
         floor_cycles   <= ndlc_pkg::MIN_RESET;
         ceiling_cycles <= ndlc_pkg::MAX_RESET;
         forecast_q.delete();
         fail_count     <= 0;
         pending        <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == ndlc_pkg::REG_MIN_CYCLES) begin
               floor_cycles <= csr_wdata[9:0];
            end else if (csr_index == ndlc_pkg::REG_MAX_CYCLES) begin
               ceiling_cycles <= csr_wdata;
            end
         end
         if (pop && !empty) begin
            if (forecast_q.size() == 0) begin
               $error("unexpected result item: achieved_cycles %0d", rsp_achieved_cycles);
               fail_count <= fail_count + 1;
            end else begin
               want = forecast_q.pop_front();
               if (rsp_inner_count !== want.inner ||
                   rsp_middle_count !== want.middle ||
                   rsp_outer_count !== want.outer ||
                   rsp_achieved_cycles !== want.achieved ||
                   rsp_overflow !== want.ovf) begin
                  fail_count <= fail_count + 1;
                  if (rsp_inner_count !== want.inner)
                     $error("inner_count: expected %0h, actual %0h",
                            want.inner, rsp_inner_count);
                  if (rsp_middle_count !== want.middle)
                     $error("middle_count: expected %0h, actual %0h",
                            want.middle, rsp_middle_count);
                  if (rsp_outer_count !== want.outer)
                     $error("outer_count: expected %0h, actual %0h",
                            want.outer, rsp_outer_count);
                  if (rsp_achieved_cycles !== want.achieved)
                     $error("achieved_cycles: expected %0d, actual %0d",
                            want.achieved, rsp_achieved_cycles);
                  if (rsp_overflow !== want.ovf)
                     $error("overflow: expected %0b, actual %0b",
                            want.ovf, rsp_overflow);
               end
            end
         end
         if (push && !full)
            forecast_q.push_back(solve_loops(req_desired_cycles, floor_cycles,
                                             ceiling_cycles));
         pending <= forecast_q.size();
      end
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Nested delay-loop counter solver testbench
// Drives directed and random delay requests through several register
// settings with random idling on both sides; the checker judges each result.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [1:0] REG_SPARE_LOW  = 2'd2;
   localparam logic [1:0] REG_SPARE_HIGH = 2'd3;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 48;

   logic        clock, reset, push, pop, csr_valid;
   logic        full, empty, csr_ready, rsp_overflow;
   logic [31:0] req_desired_cycles, rsp_achieved_cycles;
   logic [8:0]  rsp_inner_count, rsp_middle_count, rsp_outer_count;
   logic [1:0]  csr_index;
   logic [25:0] csr_wdata, ceiling_now;
   int          fail_count, pending, cycle_count, stall_left;
   bit          busy_mode;

   nested_delay_loop_counter_solver uut (.*);

   delay_solution_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("nested_delay_loop_counter_solver regression: fail");
         $finish;
      end
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (busy_mode || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         pop <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (pop && !empty) begin
         stall_left <= gap_length();
         pop <= 1'b1;
      end else begin
         pop <= 1'b1;
      end
   end

   task automatic send_item(input logic [31:0] m);
      int gap;
      req_desired_cycles <= m;
      push <= 1'b1;
      do @(posedge clock); while (full);
      gap = gap_length();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle();
      push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [25:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == ndlc_pkg::REG_MAX_CYCLES) ceiling_now = val;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_request();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return $urandom_range(0, 2);
      if (r < 25) return $urandom_range(3, 771);
      if (r < 50) return $urandom_range(772, 197125);
      if (r < 72) return $urandom_range(197126, ceiling_now > 197126 ? ceiling_now : 197126);
      if (r < 78) return ceiling_now + $urandom_range(0, 3) - 1;
      if (r < 84) return 32'd771 + $urandom_range(0, 2) - 1;
      if (r < 88) return 32'd197125 + $urandom_range(0, 2) - 1;
      if (r < 92) return $urandom_range(0, 1100);
      return $urandom();
   endfunction

   initial begin
      logic [31:0] directed[] = '{0, 1, 2, 3, 4, 770, 771, 772, 1000, 197125, 197126,
                                  50463000, 50463001, 32'hFFFFFFFF, 32'hAAAAAAAA};
      cycle_count = 0;
      reset = 1'b1;
      push = 1'b0;
      csr_valid = 1'b0;
      csr_index = ndlc_pkg::REG_MIN_CYCLES;
      csr_wdata = '0;
      req_desired_cycles = '0;
      ceiling_now = ndlc_pkg::MAX_RESET;
      busy_mode = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_item(directed[i]);
      settle();
      write_reg(ndlc_pkg::REG_MIN_CYCLES, 26'd0);
      write_reg(REG_SPARE_LOW, 26'h3FFFFFF);
      send_item(32'd0);
      send_item(32'd1);
      send_item(32'd2);
      settle();
      write_reg(ndlc_pkg::REG_MIN_CYCLES, 26'd1023);
      write_reg(ndlc_pkg::REG_MAX_CYCLES, 26'd0);
      write_reg(REG_SPARE_HIGH, 26'd5);
      send_item(32'd1022);
      send_item(32'd1023);
      send_item(32'd197125);
      send_item(32'd197126);
      settle();
      write_reg(ndlc_pkg::REG_MIN_CYCLES, 26'd3);
      write_reg(ndlc_pkg::REG_MAX_CYCLES, 26'h3FFFFFF);
      send_item(32'd67108863);
      send_item(32'd67108864);
      send_item(32'd60000000);

      for (int phase = 0; phase < 6; phase++) begin
         settle();
         busy_mode = (phase % 3 == 1);
         case ($urandom_range(0, 3))
            0: write_reg(ndlc_pkg::REG_MIN_CYCLES, 26'd0);
            1: write_reg(ndlc_pkg::REG_MIN_CYCLES, 26'd1023);
            default: write_reg(ndlc_pkg::REG_MIN_CYCLES, 26'($urandom_range(0, 1023)));
         endcase
         case ($urandom_range(0, 4))
            0: write_reg(ndlc_pkg::REG_MAX_CYCLES, 26'd0);
            1: write_reg(ndlc_pkg::REG_MAX_CYCLES, 26'h3FFFFFF);
            2: write_reg(ndlc_pkg::REG_MAX_CYCLES, ndlc_pkg::MAX_RESET);
            default: write_reg(ndlc_pkg::REG_MAX_CYCLES,
                               26'($urandom_range(0, 32'h3FFFFFF)));
         endcase
         for (int k = 0; k < 140; k++) send_item(pick_request());
      end

      settle();
      if (fail_count == 0) begin
         $display("nested_delay_loop_counter_solver regression: pass");
      end else begin
         $display("nested_delay_loop_counter_solver regression: fail");
      end
      $finish;
   end

endmodule

>>> nested_delay_loop_counter_solver.f
rtl/ndlc_pkg.sv
rtl/ndlc_front.sv
rtl/ndlc_queue.sv
rtl/ndlc_back.sv
rtl/nested_delay_loop_counter_solver.sv
rtl/ndlc_checker.sv
tb/delay_solution_checker.sv
tb/testbench.sv
